// ===== hw/rtl/luhn_pkg.sv =====
// shared constants and types for the luhn card number classifier
`timescale 1ns / 1ps
`default_nettype none
package luhn_pkg;

   // input and result field widths
   localparam int NUM_WIDTH   = 63;
   localparam int KIND_WIDTH  = 2;
   localparam int COUNT_WIDTH = 5;

   // bcd working register: nineteen decimal digits
   localparam int DIGITS      = 19;
   localparam int BCD_WIDTH   = DIGITS * 4;
   localparam int BIT_CNT_W   = $clog2(NUM_WIDTH);
   localparam int DIG_CNT_W   = $clog2(DIGITS);

   localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(NUM_WIDTH - 1);
   localparam logic [DIG_CNT_W-1:0] LAST_DIGIT = DIG_CNT_W'(DIGITS - 1);

   // allowed lengths
   localparam logic [COUNT_WIDTH-1:0] LEN_SHORT = 5'd13;
   localparam logic [COUNT_WIDTH-1:0] LEN_MID   = 5'd15;
   localparam logic [COUNT_WIDTH-1:0] LEN_LONG  = 5'd16;

   // leading digit patterns
   localparam logic [3:0] LEAD_FOUR     = 4'd4;
   localparam logic [3:0] LEAD_THREE    = 4'd3;
   localparam logic [3:0] SECOND_FOUR   = 4'd4;
   localparam logic [3:0] SECOND_SEVEN  = 4'd7;
   localparam logic [3:0] LEAD_FIVE     = 4'd5;
   localparam logic [3:0] SECOND_LOW    = 4'd1;
   localparam logic [3:0] SECOND_HIGH   = 4'd5;

   // card kind codes
   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_NONE   = 2'd0,
      KIND_FOUR   = 2'd1,
      KIND_THREES = 2'd2,
      KIND_FIVES  = 2'd3
   } kind_type;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage
`default_nettype wire

// ===== hw/rtl/luhn_card_number_classifier.sv =====
// luhn checksum and prefix classifier for a binary card number
// sequence: 63 conversion steps of a shift-and-add-3 unit, one bit per cycle, then 19
//   digit scan steps and one classify step; busy is high from the accepting edge until
//   the sequencer is idle again, and no new start is accepted meanwhile
// the result is shown for one cycle on rsp_valid; the receiver cannot stall
// reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid
`timescale 1ns / 1ps
`default_nettype none
module luhn_card_number_classifier (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [luhn_pkg::NUM_WIDTH-1:0]     req_card_number,
   output logic                                    rsp_valid,
   output logic [luhn_pkg::KIND_WIDTH-1:0]         rsp_card_kind,
   output logic                                    rsp_checksum_ok,
   output logic [luhn_pkg::COUNT_WIDTH-1:0]        rsp_digit_count
);
   import luhn_pkg::*;

   state_type                state_ff, state_in;
   logic [NUM_WIDTH-1:0]     bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]     dig_cnt_ff, dig_cnt_in;
   logic [3:0]               sum_ff, sum_in;
   logic [3:0]               prev_ff, prev_in;
   logic [3:0]               top1_ff, top1_in;
   logic [3:0]               top2_ff, top2_in;
   logic [COUNT_WIDTH-1:0]   count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   kind_type                 kind_ff, kind_in;
   logic                     ok_ff, ok_in;
   logic [COUNT_WIDTH-1:0]   rsp_count_ff, rsp_count_in;

   logic [BCD_WIDTH-1:0]     bcd_adj;
   logic [3:0]               digit;
   logic [4:0]               dbl;
   logic [3:0]               addend;
   logic [4:0]               sum_raw;
   logic                     sum_ok;
   logic                     len_ok;

   // add-3 correction on every bcd digit of five or more before the shift
   always_comb begin
      logic [3:0] d;
      bcd_adj = bcd_ff;
      for (int i = 0; i < DIGITS; i++) begin
         d = bcd_ff[i*4 +: 4];
         if (d >= 4'd5) begin
            bcd_adj[i*4 +: 4] = d + 4'd3;
         end
      end
   end

   // luhn contribution of the lowest bcd digit
   always_comb begin
      digit = bcd_ff[3:0];
      dbl   = {digit, 1'b0};
      if (dig_cnt_ff[0]) begin
         addend = (dbl >= 5'd10) ? 4'(dbl - 5'd9) : dbl[3:0];
      end else begin
         addend = digit;
      end
      sum_raw = {1'b0, sum_ff} + {1'b0, addend};
   end

   assign sum_ok = (sum_ff == 4'd0);
   assign len_ok = (count_ff == LEN_SHORT) || (count_ff == LEN_MID) || (count_ff == LEN_LONG);

   // sequencer and datapath
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      sum_in       = sum_ff;
      prev_in      = prev_ff;
      top1_in      = top1_ff;
      top2_in      = top2_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      kind_in      = kind_ff;
      ok_in        = ok_ff;
      rsp_count_in = rsp_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in     = req_card_number;
               bcd_in     = '0;
               bit_cnt_in = '0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            // one binary bit into the bcd register per cycle
            bcd_in     = {bcd_adj[BCD_WIDTH-2:0], bin_ff[NUM_WIDTH-1]};
            bin_in     = {bin_ff[NUM_WIDTH-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == LAST_BIT) begin
               dig_cnt_in = '0;
               sum_in     = '0;
               prev_in    = '0;
               top1_in    = '0;
               top2_in    = '0;
               count_in   = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one digit per cycle from the least significant end
            sum_in  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
            prev_in = digit;
            if (digit != 4'd0) begin
               count_in = COUNT_WIDTH'(dig_cnt_ff) + 1'b1;
               top1_in  = digit;
               top2_in  = prev_ff;
            end
            bcd_in     = {4'd0, bcd_ff[BCD_WIDTH-1:4]};
            dig_cnt_in = dig_cnt_ff + 1'b1;
            if (dig_cnt_ff == LAST_DIGIT) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // classify by checksum, length and leading digits
            kind_in = KIND_NONE;
            if (sum_ok && len_ok) begin
               priority if (((count_ff == LEN_SHORT) || (count_ff == LEN_LONG))
                            && (top1_ff == LEAD_FOUR)) begin
                  kind_in = KIND_FOUR;
               end else if ((count_ff == LEN_MID) && (top1_ff == LEAD_THREE)
                            && ((top2_ff == SECOND_FOUR) || (top2_ff == SECOND_SEVEN))) begin
                  kind_in = KIND_THREES;
               end else if ((count_ff == LEN_LONG) && (top1_ff == LEAD_FIVE)
                            && (top2_ff >= SECOND_LOW) && (top2_ff <= SECOND_HIGH)) begin
                  kind_in = KIND_FIVES;
               end else begin
                  kind_in = KIND_NONE;
               end
            end
            ok_in        = sum_ok;
            rsp_count_in = count_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      dig_cnt_ff   <= dig_cnt_in;
      sum_ff       <= sum_in;
      prev_ff      <= prev_in;
      top1_ff      <= top1_in;
      top2_ff      <= top2_in;
      count_ff     <= count_in;
      kind_ff      <= kind_in;
      ok_ff        <= ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   // outputs
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_kind   = kind_ff;
   assign rsp_checksum_ok = ok_ff;
   assign rsp_digit_count = rsp_count_ff;

endmodule
`default_nettype wire
